[hdl/hrbp_pkg.sv]
// Package for the HTTP response byte parser: parse phases, widths and
// character class helpers. No dependencies.
`default_nettype none
package hrbp_pkg;

  localparam int COUNT_BITS = 31;
  localparam int LEFT_W     = COUNT_BITS + 1;
  localparam int NAME_CAP   = 18;
  localparam int VALUE_CAP  = 11;

  typedef enum logic [4:0] {
    PH_H, PH_T1, PH_T2, PH_P, PH_SLASH, PH_MAJ0, PH_MAJ, PH_MIN0, PH_MIN,
    PH_CODE1, PH_CODE2, PH_CODE3, PH_SP_REASON, PH_REASON, PH_LF1,
    PH_LINE_START, PH_LWS, PH_NAME, PH_SP_VALUE, PH_VALUE, PH_LF2, PH_LF3,
    PH_BODY, PH_CSIZE0, PH_CSIZE, PH_LF4, PH_CHUNK, PH_LF5
  } phase_t;

  localparam logic [1:0] VERDICT_MORE = 2'd0;
  localparam logic [1:0] VERDICT_GOOD = 2'd1;
  localparam logic [1:0] VERDICT_BAD  = 2'd2;

  localparam logic [2:0] DEC_BLANK = 3'd0;
  localparam logic [2:0] DEC_SIGN  = 3'd1;
  localparam logic [2:0] DEC_DIGIT = 3'd2;
  localparam logic [2:0] DEC_DONE  = 3'd3;
  localparam logic [2:0] DEC_DEAD  = 3'd4;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        reason_valid;
    logic [7:0]  reason_byte;
    logic [9:0]  status_number;
    logic [7:0]  major_version;
    logic [7:0]  minor_version;
    logic        is_chunked;
    logic        wants_keep_alive;
    logic [30:0] declared_length;
  } result_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b < 8'd32) || (b == 8'd127);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_tsp(input logic [7:0] b);
    logic r;
    unique case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "=", "{", "}", " ", 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // 5 bits: [4] valid, [3:0] digit value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    if (is_dig(b)) r = {1'b1, b[3:0]};
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
      r = {1'b1, b[3:0] + 4'd9};
    else r = 5'd0;
    return r;
  endfunction

  function automatic logic [7:0] sat_dec(input logic [7:0] acc, input logic [7:0] b);
    logic [11:0] v;
    v = 12'(acc) * 12'd10 + 12'(b[3:0]);
    return (v > 12'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [4:0] p);
    string s;
    unique case (k)
      2'd0:    s = "content-length";
      2'd1:    s = "transfer-encoding";
      default: s = "connection";
    endcase
    return (int'(p) < s.len()) ? s[p] : 8'd0;
  endfunction

  function automatic logic [4:0] hdr_len(input logic [1:0] k);
    logic [4:0] r;
    unique case (k)
      2'd0:    r = 5'd14;
      2'd1:    r = 5'd17;
      default: r = 5'd10;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] val_char(input logic k, input logic [3:0] p);
    string s;
    s = k ? "keep-alive" : "chunked";
    return (int'(p) < s.len()) ? s[p] : 8'd0;
  endfunction

  function automatic logic [3:0] val_len(input logic k);
    return k ? 4'd10 : 4'd7;
  endfunction

endpackage
`default_nettype wire

[hdl/hrbp_core.sv]
// Parser core: state registers and the one-byte next-state logic.
// Depends on hrbp_pkg.
`default_nettype none
module hrbp_core
  import hrbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_new,
  output result_t         res
);

  localparam int                WIDE_W  = LEFT_W + 4;
  localparam logic [LEFT_W-1:0] NUM_MAX = {1'b0, {COUNT_BITS{1'b1}}};
  localparam logic [LEFT_W-1:0] ALL_ONE = '1;

  phase_t            phase, phase_next;
  logic [7:0]        major_acc, major_acc_next, minor_acc, minor_acc_next;
  logic [9:0]        code_acc, code_acc_next;
  logic              any_hdr, any_hdr_next;
  logic [4:0]        name_pos, name_pos_next;
  logic [2:0]        name_cand, name_cand_next;
  logic [3:0]        value_pos, value_pos_next;
  logic [1:0]        value_cand, value_cand_next;
  logic [LEFT_W-1:0] num_acc, num_acc_next;
  logic              num_over, num_over_next;
  logic [2:0]        dec, dec_next;
  logic [LEFT_W-1:0] length_left, length_left_next, chunk_left, chunk_left_next;
  logic [30:0]       declared, declared_next;
  logic              chunked, chunked_next, keep, keep_next;

  // state seen by this byte, after an optional clear
  phase_t            c_phase;
  logic [7:0]        c_major, c_minor;
  logic [9:0]        c_code;
  logic              c_any, c_num_over, c_chunked, c_keep;
  logic [4:0]        c_name_pos;
  logic [2:0]        c_name_cand;
  logic [3:0]        c_value_pos;
  logic [1:0]        c_value_cand;
  logic [LEFT_W-1:0] c_num, c_length, c_chunk;
  logic [2:0]        c_dec;
  logic [30:0]       c_decl;

  always_comb begin
    if (start_new) begin
      c_phase = PH_H; c_major = '0; c_minor = '0; c_code = '0; c_any = 1'b0;
      c_name_pos = '0; c_name_cand = '0; c_value_pos = '0; c_value_cand = '0;
      c_num = '0; c_num_over = 1'b0; c_dec = DEC_BLANK; c_length = '0;
      c_chunk = '0; c_decl = '0; c_chunked = 1'b0; c_keep = 1'b0;
    end else begin
      c_phase = phase; c_major = major_acc; c_minor = minor_acc; c_code = code_acc;
      c_any = any_hdr; c_name_pos = name_pos; c_name_cand = name_cand;
      c_value_pos = value_pos; c_value_cand = value_cand; c_num = num_acc;
      c_num_over = num_over; c_dec = dec; c_length = length_left; c_chunk = chunk_left;
      c_decl = declared; c_chunked = chunked; c_keep = keep;
    end
  end

  logic [7:0]        lb;
  logic [4:0]        hx;
  logic              ctl, dig, tsp, hi;
  logic [2:0]        nm_keep;
  logic [1:0]        vl_keep;
  logic              name_cl, name_te, name_cn, val_ch, val_ka;
  logic [WIDE_W-1:0] dec_wide;
  logic [LEFT_W-1:0] hex_lim;
  logic [LEFT_W-1:0] len_dec, chunk_dec;
  logic [1:0]        verdict;
  logic              body, reason;

  always_comb begin
    lb  = lower(in_byte);
    hx  = hex_val(in_byte);
    ctl = is_ctl(in_byte);
    dig = is_dig(in_byte);
    tsp = is_tsp(in_byte);
    hi  = in_byte[7];
    for (int k = 0; k < 3; k++)
      nm_keep[k] = (c_name_pos < hdr_len(2'(k))) && (lb == hdr_char(2'(k), c_name_pos));
    for (int k = 0; k < 2; k++)
      vl_keep[k] = (c_value_pos < val_len(1'(k))) && (lb == val_char(1'(k), c_value_pos));
    name_cl = c_name_cand[0] && (c_name_pos == hdr_len(2'd0));
    name_te = c_name_cand[1] && (c_name_pos == hdr_len(2'd1));
    name_cn = c_name_cand[2] && (c_name_pos == hdr_len(2'd2));
    val_ch  = c_value_cand[0] && (c_value_pos == val_len(1'b0));
    val_ka  = c_value_cand[1] && (c_value_pos == val_len(1'b1));
    // decimal step as num*8 + num*2 + digit, overflow when above the limit
    dec_wide = ({4'd0, c_num} << 3) + ({4'd0, c_num} << 1) + WIDE_W'(in_byte[3:0]);
    hex_lim = (NUM_MAX - LEFT_W'(hx[3:0])) >> 4;
    len_dec   = c_length - 1'b1;
    chunk_dec = c_chunk - 1'b1;
  end

  always_comb begin
    phase_next = c_phase; major_acc_next = c_major; minor_acc_next = c_minor;
    code_acc_next = c_code; any_hdr_next = c_any; name_pos_next = c_name_pos;
    name_cand_next = c_name_cand; value_pos_next = c_value_pos;
    value_cand_next = c_value_cand; num_acc_next = c_num; num_over_next = c_num_over;
    dec_next = c_dec; length_left_next = c_length; chunk_left_next = c_chunk;
    declared_next = c_decl; chunked_next = c_chunked; keep_next = c_keep;
    verdict = VERDICT_MORE; body = 1'b0; reason = 1'b0;

    unique case (c_phase)
      PH_H:  if (in_byte == "H") phase_next = PH_T1; else verdict = VERDICT_BAD;
      PH_T1: if (in_byte == "T") phase_next = PH_T2; else verdict = VERDICT_BAD;
      PH_T2: if (in_byte == "T") phase_next = PH_P; else verdict = VERDICT_BAD;
      PH_P:  if (in_byte == "P") phase_next = PH_SLASH; else verdict = VERDICT_BAD;
      PH_SLASH: begin
        if (in_byte == "/") begin
          major_acc_next = '0; minor_acc_next = '0; phase_next = PH_MAJ0;
        end else verdict = VERDICT_BAD;
      end
      PH_MAJ0: begin
        if (dig) begin
          major_acc_next = sat_dec(c_major, in_byte); phase_next = PH_MAJ;
        end else verdict = VERDICT_BAD;
      end
      PH_MAJ: begin
        if (in_byte == ".") phase_next = PH_MIN0;
        else if (dig) major_acc_next = sat_dec(c_major, in_byte);
        else verdict = VERDICT_BAD;
      end
      PH_MIN0: begin
        if (dig) begin
          minor_acc_next = sat_dec(c_minor, in_byte); phase_next = PH_MIN;
        end else verdict = VERDICT_BAD;
      end
      PH_MIN: begin
        if (in_byte == " ") phase_next = PH_CODE1;
        else if (dig) minor_acc_next = sat_dec(c_minor, in_byte);
        else verdict = VERDICT_BAD;
      end
      PH_CODE1: begin
        if (in_byte >= "1" && in_byte <= "5") begin
          code_acc_next = 10'(in_byte[3:0]); phase_next = PH_CODE2;
        end else verdict = VERDICT_BAD;
      end
      PH_CODE2, PH_CODE3: begin
        if (dig) begin
          code_acc_next = 10'(c_code * 10'd10 + 10'(in_byte[3:0]));
          phase_next = (c_phase == PH_CODE2) ? PH_CODE3 : PH_SP_REASON;
        end else verdict = VERDICT_BAD;
      end
      PH_SP_REASON: if (in_byte == " ") phase_next = PH_REASON; else verdict = VERDICT_BAD;
      PH_REASON: begin
        if (in_byte == 8'h0D) phase_next = PH_LF1;
        else if (hi || ctl || (tsp && in_byte != " ")) verdict = VERDICT_BAD;
        else reason = 1'b1;
      end
      PH_LF1: if (in_byte == 8'h0A) phase_next = PH_LINE_START; else verdict = VERDICT_BAD;
      PH_LINE_START: begin
        if (in_byte == 8'h0D) phase_next = PH_LF3;
        else if (c_any && (in_byte == " " || in_byte == 8'h09)) phase_next = PH_LWS;
        else if (hi || ctl || tsp) verdict = VERDICT_BAD;
        else begin
          any_hdr_next = 1'b1;
          name_pos_next = 5'd1;
          name_cand_next = {(lb == "c"), (lb == "t"), (lb == "c")};
          value_pos_next = '0; value_cand_next = 2'b11;
          num_acc_next = '0; num_over_next = 1'b0; dec_next = DEC_BLANK;
          phase_next = PH_NAME;
        end
      end
      PH_NAME: begin
        if (in_byte == ":") phase_next = PH_SP_VALUE;
        else if (hi || ctl || tsp) verdict = VERDICT_BAD;
        else begin
          name_cand_next = c_name_cand & nm_keep;
          if (c_name_pos < 5'(NAME_CAP)) name_pos_next = c_name_pos + 5'd1;
        end
      end
      PH_SP_VALUE: if (in_byte == " ") phase_next = PH_VALUE; else verdict = VERDICT_BAD;
      PH_LWS, PH_VALUE: begin
        if (in_byte == 8'h0D) begin
          if (c_phase == PH_LWS) phase_next = PH_LF2;
          else if (name_cl && ((c_dec != DEC_DIGIT && c_dec != DEC_DONE) || c_num_over))
            verdict = VERDICT_BAD;
          else begin
            if (name_cl) begin
              length_left_next = c_num; declared_next = c_num[30:0];
            end
            if (name_te && val_ch) chunked_next = 1'b1;
            if (name_cn && val_ka) keep_next = 1'b1;
            phase_next = PH_LF2;
          end
        end else if (c_phase == PH_LWS && (in_byte == " " || in_byte == 8'h09)) begin
          phase_next = PH_LWS;
        end else if (ctl) verdict = VERDICT_BAD;
        else begin
          phase_next = PH_VALUE;
          value_cand_next = c_value_cand & vl_keep;
          if (c_value_pos < 4'(VALUE_CAP)) value_pos_next = c_value_pos + 4'd1;
          // digit accumulate shared by the decimal scan states
          if ((c_dec == DEC_BLANK || c_dec == DEC_SIGN || c_dec == DEC_DIGIT) && dig) begin
            dec_next = DEC_DIGIT;
            if (!c_num_over) begin
              if (dec_wide > WIDE_W'(NUM_MAX)) num_over_next = 1'b1;
              else num_acc_next = dec_wide[LEFT_W-1:0];
            end
          end else begin
            priority case (c_dec)
              DEC_BLANK: begin
                if (in_byte == "+") dec_next = DEC_SIGN;
                else if (in_byte != " ") dec_next = DEC_DEAD;
              end
              DEC_SIGN:  dec_next = DEC_DEAD;
              DEC_DIGIT: dec_next = DEC_DONE;
              default:   dec_next = c_dec;
            endcase
          end
        end
      end
      PH_LF2: if (in_byte == 8'h0A) phase_next = PH_LINE_START; else verdict = VERDICT_BAD;
      PH_LF3: begin
        if (in_byte != 8'h0A) verdict = VERDICT_BAD;
        else if (c_chunked) phase_next = PH_CSIZE0;
        else if (c_length == '0) verdict = VERDICT_GOOD;
        else phase_next = PH_BODY;
      end
      PH_BODY: begin
        length_left_next = len_dec; body = 1'b1;
        if (len_dec == '0) verdict = VERDICT_GOOD;
      end
      PH_CSIZE0: begin
        if (hx[4]) begin
          num_acc_next = LEFT_W'(hx[3:0]); num_over_next = 1'b0; phase_next = PH_CSIZE;
        end else verdict = VERDICT_BAD;
      end
      PH_CSIZE: begin
        if (hx[4]) begin
          if (!c_num_over) begin
            if (c_num > hex_lim) num_over_next = 1'b1;
            else num_acc_next = {c_num[LEFT_W-5:0], hx[3:0]};
          end
        end else if (in_byte == 8'h0D) begin
          phase_next = PH_LF4;
          if (c_num_over) verdict = VERDICT_BAD;
          else begin
            chunk_left_next = c_num;
            if (c_num == '0) verdict = VERDICT_GOOD;
          end
        end else verdict = VERDICT_BAD;
      end
      PH_LF4: if (in_byte == 8'h0A) phase_next = PH_CHUNK; else verdict = VERDICT_BAD;
      PH_CHUNK: begin
        chunk_left_next = chunk_dec;
        if (in_byte == 8'h0D && chunk_dec == ALL_ONE) phase_next = PH_LF5;
        else body = 1'b1;
      end
      PH_LF5: if (in_byte == 8'h0A) phase_next = PH_CSIZE0; else verdict = VERDICT_BAD;
      default: verdict = VERDICT_BAD;
    endcase

    // a bad byte leaves state as it was, except the chunk size CR
    if (verdict == VERDICT_BAD && !(c_phase == PH_CSIZE && in_byte == 8'h0D && !hx[4])) begin
      phase_next = c_phase; major_acc_next = c_major; minor_acc_next = c_minor;
      code_acc_next = c_code; any_hdr_next = c_any; name_pos_next = c_name_pos;
      name_cand_next = c_name_cand; value_pos_next = c_value_pos;
      value_cand_next = c_value_cand; num_acc_next = c_num; num_over_next = c_num_over;
      dec_next = c_dec; length_left_next = c_length; chunk_left_next = c_chunk;
      declared_next = c_decl; chunked_next = c_chunked; keep_next = c_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_H; major_acc <= '0; minor_acc <= '0; code_acc <= '0;
      any_hdr <= 1'b0; name_pos <= '0; name_cand <= '0; value_pos <= '0;
      value_cand <= '0; num_acc <= '0; num_over <= 1'b0; dec <= DEC_BLANK;
      length_left <= '0; chunk_left <= '0; declared <= '0;
      chunked <= 1'b0; keep <= 1'b0;
    end else if (step) begin
      phase <= phase_next; major_acc <= major_acc_next; minor_acc <= minor_acc_next;
      code_acc <= code_acc_next; any_hdr <= any_hdr_next; name_pos <= name_pos_next;
      name_cand <= name_cand_next; value_pos <= value_pos_next;
      value_cand <= value_cand_next; num_acc <= num_acc_next; num_over <= num_over_next;
      dec <= dec_next; length_left <= length_left_next; chunk_left <= chunk_left_next;
      declared <= declared_next; chunked <= chunked_next; keep <= keep_next;
    end
  end

  always_comb begin
    res.verdict          = verdict;
    res.body_valid       = body;
    res.body_byte        = body ? in_byte : 8'd0;
    res.reason_valid     = reason;
    res.reason_byte      = reason ? in_byte : 8'd0;
    res.status_number    = code_acc_next;
    res.major_version    = major_acc_next;
    res.minor_version    = minor_acc_next;
    res.is_chunked       = chunked_next;
    res.wants_keep_alive = keep_next;
    res.declared_length  = declared_next;
  end

  ap_num_bound: assert property (@(posedge clk) disable iff (rst)
    !num_over |-> num_acc <= NUM_MAX) else $error("number above limit");
  ap_bad_hold: assert property (@(posedge clk) disable iff (rst)
    (step && !start_new && verdict == VERDICT_BAD && phase != PH_CSIZE) |=> $stable(phase))
    else $error("phase moved on bad byte");
  ap_excl: assert property (@(posedge clk) disable iff (rst) !(body && reason))
    else $error("body and reason together");

endmodule
`default_nettype wire

[hdl/http_response_byte_parser_top.sv]
// Top level of the HTTP response byte parser: input register, parser core,
// result output register. Depends on hrbp_pkg and hrbp_core.
//
// Usage: one response byte per s_axis transfer (tdata = in_byte, tuser =
// start_new); one result per byte on m_axis. A byte sits in the input
// register until the output register can take a result; the core's
// single-pass logic then updates the parse state and forms the result
// into the output register. Each result thus passes the input and output
// registers in turn, and one byte per cycle is sustained while the
// receiver keeps m_axis_tready high.
// When the receiver stalls, the output register holds its result, the
// input register holds the next byte, and s_axis_tready drops once both
// are full. Synchronous reset empties both registers and returns the
// parser to expecting the 'H' of the status line.
`default_nettype none
module http_response_byte_parser_top
  import hrbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic        s_axis_tuser,   // start_new
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata [79:0]: verdict[1:0], body_valid, body_byte, reason_valid,
  // reason_byte, status_number, major_version, minor_version, is_chunked,
  // wants_keep_alive, declared_length, zero fill
  output logic [79:0]      m_axis_tdata
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       step;
  result_t    res, out_res;

  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  hrbp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (in_byte),
    .start_new (in_start),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (step) out_res <= res;
  end

  assign m_axis_tdata = {1'b0, out_res.declared_length, out_res.wants_keep_alive,
                         out_res.is_chunked, out_res.minor_version,
                         out_res.major_version, out_res.status_number,
                         out_res.reason_byte, out_res.reason_valid,
                         out_res.body_byte, out_res.body_valid, out_res.verdict};

  ap_no_loss: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  ap_step: assert property (@(posedge clk) disable iff (rst)
    step |=> m_axis_tvalid) else $error("result missing");
  ap_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("accepted while full");

endmodule
`default_nettype wire

[tb/sv/tb_http_response_byte_parser_top.sv]
// Testbench for http_response_byte_parser_top: feeds byte streams of HTTP
// responses, predicts each per-byte result and checks it in order.
// Depends on hrbp_pkg and the parser RTL only.
`default_nettype none
module tb_http_response_byte_parser_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrbp_pkg::*;

  localparam longint unsigned NUM_LIMIT = (64'd1 << COUNT_BITS) - 1;
  localparam longint unsigned WRAP_MASK = (64'd2 << COUNT_BITS) - 1;
  localparam byte unsigned CR = 8'h0d;
  localparam byte unsigned LF = 8'h0a;

  // Tracks parse state of the response stream and holds pending results.
  class response_tracker;
    phase_t          ph;
    logic [7:0]      maj, mnr;
    logic [9:0]      code;
    bit              hdr_seen;
    int              npos, vpos;
    bit [2:0]        ncand;
    bit [1:0]        vcand;
    longint unsigned num, body_left, chunk_left, decl;
    bit              ovf;
    logic [2:0]      dec;
    bit              chunked, keep;
    result_t         pending_q[$];
    int              errors;
    string           hnames[3] = '{"content-length", "transfer-encoding", "connection"};
    string           vnames[2] = '{"chunked", "keep-alive"};

    function void clear();
      ph = PH_H; maj = 0; mnr = 0; code = 0; hdr_seen = 0;
      npos = 0; ncand = 0; vpos = 0; vcand = 0;
      num = 0; ovf = 0; dec = DEC_BLANK;
      body_left = 0; chunk_left = 0; decl = 0; chunked = 0; keep = 0;
    endfunction

    function new();
      clear();
      errors = 0;
    endfunction

    function bit digit(byte unsigned b);
      return b >= "0" && b <= "9";
    endfunction

    function bit ctl(byte unsigned b);
      return b < 32 || b == 127;
    endfunction

    function bit sep(byte unsigned b);
      return b inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[",
                       "]", "?", "=", "{", "}", " ", 8'h09};
    endfunction

    function byte unsigned lc(byte unsigned b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function int hexd(byte unsigned b);
      if (digit(b)) return b - 48;
      if (b >= "a" && b <= "f") return b - 87;
      if (b >= "A" && b <= "F") return b - 55;
      return -1;
    endfunction

    function logic [7:0] ver_digit(logic [7:0] acc, byte unsigned b);
      int x;
      x = acc * 10 + (b - 48);
      return x > 255 ? 8'd255 : x[7:0];
    endfunction

    function void add_digit(int d, int base);
      if (ovf) return;
      if (num > (NUM_LIMIT - d) / base) ovf = 1;
      else num = num * base + d;
    endfunction

    function void name_step(byte unsigned b);
      for (int k = 0; k < 3; k++)
        if (npos >= hnames[k].len() || lc(b) != hnames[k][npos]) ncand[k] = 0;
      if (npos < NAME_CAP) npos++;
    endfunction

    function void value_step(byte unsigned b);
      for (int k = 0; k < 2; k++)
        if (vpos >= vnames[k].len() || lc(b) != vnames[k][vpos]) vcand[k] = 0;
      if (vpos < VALUE_CAP) vpos++;
      case (dec)
        DEC_BLANK: begin
          if (b == "+") dec = DEC_SIGN;
          else if (digit(b)) begin
            add_digit(b - 48, 10);
            dec = DEC_DIGIT;
          end else if (b != " ") dec = DEC_DEAD;
        end
        DEC_SIGN: begin
          if (digit(b)) begin
            add_digit(b - 48, 10);
            dec = DEC_DIGIT;
          end else dec = DEC_DEAD;
        end
        DEC_DIGIT: begin
          if (digit(b)) add_digit(b - 48, 10);
          else dec = DEC_DONE;
        end
        default: ;
      endcase
    endfunction

    function bit name_hit(int k);
      return ncand[k] && npos == hnames[k].len();
    endfunction

    function bit value_hit(int k);
      return vcand[k] && vpos == vnames[k].len();
    endfunction

    function result_t next_result(byte unsigned b, bit restart);
      result_t r;
      logic [1:0] v;
      bit body, rsn;
      int h;
      if (restart) clear();
      v = VERDICT_MORE; body = 0; rsn = 0;
      case (ph)
        PH_H:  if (b == "H") ph = PH_T1; else v = VERDICT_BAD;
        PH_T1: if (b == "T") ph = PH_T2; else v = VERDICT_BAD;
        PH_T2: if (b == "T") ph = PH_P; else v = VERDICT_BAD;
        PH_P:  if (b == "P") ph = PH_SLASH; else v = VERDICT_BAD;
        PH_SLASH: begin
          if (b == "/") begin
            maj = 0; mnr = 0; ph = PH_MAJ0;
          end else v = VERDICT_BAD;
        end
        PH_MAJ0: begin
          if (digit(b)) begin
            maj = ver_digit(maj, b); ph = PH_MAJ;
          end else v = VERDICT_BAD;
        end
        PH_MAJ: begin
          if (b == ".") ph = PH_MIN0;
          else if (digit(b)) maj = ver_digit(maj, b);
          else v = VERDICT_BAD;
        end
        PH_MIN0: begin
          if (digit(b)) begin
            mnr = ver_digit(mnr, b); ph = PH_MIN;
          end else v = VERDICT_BAD;
        end
        PH_MIN: begin
          if (b == " ") ph = PH_CODE1;
          else if (digit(b)) mnr = ver_digit(mnr, b);
          else v = VERDICT_BAD;
        end
        PH_CODE1: begin
          if (b >= "1" && b <= "5") begin
            code = 10'(b - 48); ph = PH_CODE2;
          end else v = VERDICT_BAD;
        end
        PH_CODE2, PH_CODE3: begin
          if (digit(b)) begin
            code = 10'(code * 10 + (b - 48));
            ph = (ph == PH_CODE2) ? PH_CODE3 : PH_SP_REASON;
          end else v = VERDICT_BAD;
        end
        PH_SP_REASON: if (b == " ") ph = PH_REASON; else v = VERDICT_BAD;
        PH_REASON: begin
          if (b == CR) ph = PH_LF1;
          else if (b >= 128 || ctl(b) || (sep(b) && b != " ")) v = VERDICT_BAD;
          else rsn = 1;
        end
        PH_LF1: if (b == LF) ph = PH_LINE_START; else v = VERDICT_BAD;
        PH_LINE_START: begin
          if (b == CR) ph = PH_LF3;
          else if (hdr_seen && (b == " " || b == 8'h09)) ph = PH_LWS;
          else if (b >= 128 || ctl(b) || sep(b)) v = VERDICT_BAD;
          else begin
            hdr_seen = 1;
            npos = 0; ncand = 3'b111; vpos = 0; vcand = 2'b11;
            num = 0; ovf = 0; dec = DEC_BLANK;
            name_step(b);
            ph = PH_NAME;
          end
        end
        PH_LWS: begin
          if (b == CR) ph = PH_LF2;
          else if (b == " " || b == 8'h09) ;
          else if (ctl(b)) v = VERDICT_BAD;
          else begin
            value_step(b); ph = PH_VALUE;
          end
        end
        PH_NAME: begin
          if (b == ":") ph = PH_SP_VALUE;
          else if (b >= 128 || ctl(b) || sep(b)) v = VERDICT_BAD;
          else name_step(b);
        end
        PH_SP_VALUE: if (b == " ") ph = PH_VALUE; else v = VERDICT_BAD;
        PH_VALUE: begin
          if (b == CR) begin
            // a broken length rejects the whole line, flags included
            if (name_hit(0)) begin
              if ((dec != DEC_DIGIT && dec != DEC_DONE) || ovf) v = VERDICT_BAD;
              else begin
                body_left = num; decl = num;
              end
            end
            if (v != VERDICT_BAD) begin
              if (name_hit(1) && value_hit(0)) chunked = 1;
              if (name_hit(2) && value_hit(1)) keep = 1;
              ph = PH_LF2;
            end
          end else if (ctl(b)) v = VERDICT_BAD;
          else value_step(b);
        end
        PH_LF2: if (b == LF) ph = PH_LINE_START; else v = VERDICT_BAD;
        PH_LF3: begin
          if (b != LF) v = VERDICT_BAD;
          else if (chunked) ph = PH_CSIZE0;
          else if (body_left == 0) v = VERDICT_GOOD;
          else ph = PH_BODY;
        end
        PH_BODY: begin
          body_left = (body_left - 1) & WRAP_MASK;
          body = 1;
          if (body_left == 0) v = VERDICT_GOOD;
        end
        PH_CSIZE0: begin
          h = hexd(b);
          if (h >= 0) begin
            num = 64'(h); ovf = 0; ph = PH_CSIZE;
          end else v = VERDICT_BAD;
        end
        PH_CSIZE: begin
          h = hexd(b);
          if (h >= 0) add_digit(h, 16);
          else if (b == CR) begin
            // overflow still advances the phase
            ph = PH_LF4;
            if (ovf) v = VERDICT_BAD;
            else begin
              chunk_left = num;
              if (chunk_left == 0) v = VERDICT_GOOD;
            end
          end else v = VERDICT_BAD;
        end
        PH_LF4: if (b == LF) ph = PH_CHUNK; else v = VERDICT_BAD;
        PH_CHUNK: begin
          chunk_left = (chunk_left - 1) & WRAP_MASK;
          if (b == CR && chunk_left == WRAP_MASK) ph = PH_LF5;
          else body = 1;
        end
        PH_LF5: if (b == LF) ph = PH_CSIZE0; else v = VERDICT_BAD;
        default: v = VERDICT_BAD;
      endcase
      r.verdict = v;
      r.body_valid = body;
      r.body_byte = body ? b : 8'd0;
      r.reason_valid = rsn;
      r.reason_byte = rsn ? b : 8'd0;
      r.status_number = code;
      r.major_version = maj;
      r.minor_version = mnr;
      r.is_chunked = chunked;
      r.wants_keep_alive = keep;
      r.declared_length = decl[30:0];
      return r;
    endfunction

    function void note_byte(byte unsigned b, bit restart);
      pending_q.insert(pending_q.size(), next_result(b, restart));
    endfunction

    function void compare(string fname, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", fname, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [79:0] d);
      result_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with no byte outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      compare("verdict", e.verdict, d[1:0]);
      compare("body_valid", e.body_valid, d[2]);
      compare("body_byte", e.body_byte, d[10:3]);
      compare("reason_valid", e.reason_valid, d[11]);
      compare("reason_byte", e.reason_byte, d[19:12]);
      compare("status_number", e.status_number, d[29:20]);
      compare("major_version", e.major_version, d[37:30]);
      compare("minor_version", e.minor_version, d[45:38]);
      compare("is_chunked", e.is_chunked, d[46]);
      compare("wants_keep_alive", e.wants_keep_alive, d[47]);
      compare("declared_length", e.declared_length, d[78:48]);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;

  response_tracker tracker = new();
  byte unsigned    byte_q[$];
  bit              first_q[$];
  bit              calm = 0;
  bit              hold_req = 0;

  http_response_byte_parser_top uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata, s_axis_tuser);
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver backpressure
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1;
        stall = 80;
      end else if (stall == 0) stall = pick_gap();
      m_axis_tready = (stall == 0);
      if (stall > 0) stall--;
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      byte_q.insert(byte_q.size(), s[i]);
      first_q.insert(first_q.size(), 0);
    end
  endtask

  task automatic add_raw(byte unsigned b);
    byte_q.insert(byte_q.size(), b);
    first_q.insert(first_q.size(), 0);
  endtask

  function automatic string mix_case(string s);
    for (int i = 0; i < s.len(); i++)
      if (((s[i] >= "a" && s[i] <= "z") || (s[i] >= "A" && s[i] <= "Z"))
          && $urandom_range(0, 1))
        s[i] = s[i] ^ 8'h20;
    return s;
  endfunction

  function automatic string token(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(0, 1)
        ? $urandom_range(65, 90) : $urandom_range(97, 122)))};
    return s;
  endfunction

  task automatic gen_message();
    int start, n, len, kind;
    bit use_chunks;
    string v;
    start = byte_q.size();
    if ($urandom_range(0, 9) == 0) begin
      // line noise
      n = $urandom_range(1, 8);
      repeat (n) add_raw($urandom_range(0, 255));
    end else begin
      add_text($sformatf("HTTP/%0d.%0d %0d %s\r\n",
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 9999) : $urandom_range(0, 9),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 9999) : $urandom_range(0, 9),
                         $urandom_range(100, 599), token($urandom_range(0, 4))));
      use_chunks = $urandom_range(0, 2) == 0;
      len = $urandom_range(0, 6);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin
            case ($urandom_range(0, 9))
              0: v = "-3";
              1: v = "";
              2: v = "3000000000";
              3: v = $sformatf("%0dab", len);
              4: v = $sformatf("  +%0d", len);
              default: v = $sformatf("%0d", len);
            endcase
            add_text({mix_case("Content-Length"), ": ", v, "\r\n"});
          end
          1: add_text({mix_case("Transfer-Encoding"), ": ",
                       use_chunks ? mix_case("chunked") : "gzip", "\r\n"});
          2: add_text({mix_case("Connection"), ": ",
                       $urandom_range(0, 2) ? mix_case("Keep-Alive") : "close", "\r\n"});
          default: begin
            add_text({"X-", token($urandom_range(1, 5)), ": "});
            repeat ($urandom_range(0, 4)) add_raw($urandom_range(32, 255));
            add_text("\r\n");
          end
        endcase
        if ($urandom_range(0, 5) == 0) add_text({" \t", token(2), "\r\n"});
      end
      add_text("\r\n");
      if (use_chunks) begin
        repeat ($urandom_range(0, 2)) begin
          n = $urandom_range(0, 5);
          add_text({mix_case($sformatf("%0h", n)), "\r\n"});
          repeat (n) add_raw($urandom_range(0, 255));
          add_text("\r\n");
        end
        if ($urandom_range(0, 9) == 0) add_text("1fffffffff\r\n");
        add_text("0\r\n");
      end else begin
        repeat (len) add_raw($urandom_range(0, 255));
      end
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) add_raw($urandom_range(0, 255));
    end
    if ($urandom_range(0, 6) == 0)
      byte_q[$urandom_range(start, byte_q.size() - 1)] = $urandom_range(0, 255);
    first_q[start] = 1;
  endtask

  task automatic send_byte(byte unsigned b, bit first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = b;
    s_axis_tuser = first;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (tracker.pending_q.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    int sent;
    bit drained;
    drained = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: saturating versions, empty body with repeated good,
    // signed length plus continuation, chunk CR handling and size overflow,
    // minus sign, high byte in the value of the rejected length line
    add_text("HTTP/999.1000 100 A\r\n\r\n\n");
    first_q[0] = 1;
    sent = byte_q.size();
    add_text("HTTP/0.0 599 Ok go\r\nContent-Length: +2\r\nConnection: keep-ALIVE\r\n  x\r\n\r\n");
    add_raw(8'h00); add_raw(8'hff); add_raw(8'h41);
    first_q[sent] = 1;
    sent = byte_q.size();
    add_text("HTTP/1.1 200 OK\r\nTransfer-Encoding: Chunked\r\n\r\n2\r\n\r\r\r\n1FFFFFFFF\r\n");
    first_q[sent] = 1;
    sent = byte_q.size();
    add_text("HTTP/1.1 404 N\r\nContent-Length: -1\r\nX");
    add_raw(8'h80);
    first_q[sent] = 1;

    while (byte_q.size() < 520) gen_message();

    sent = 0;
    while (byte_q.size() > 0) begin
      if (first_q[0]) begin
        calm = ($urandom_range(0, 3) == 0);
        if (!drained && sent > 350) begin
          drained = 1;
          s_axis_tvalid = 0;
          wait_drained();
          @(negedge clk);
        end
      end
      if (sent == 200) hold_req = 1;
      send_byte(byte_q.pop_front(), first_q.pop_front());
      sent++;
    end
    s_axis_tvalid = 0;
    calm = 1;
    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

[http_response_byte_parser_top.f]
hdl/hrbp_pkg.sv
hdl/hrbp_core.sv
hdl/http_response_byte_parser_top.sv
tb/sv/tb_http_response_byte_parser_top.sv
